/* rtl/jtos_pkg.sv */
// jtos_pkg: shared constants and types for the JSON top-level object splitter.
// Used by jtos_scan, jtos_outq and json_top_object_splitter; no dependencies.

package jtos_pkg;

   // Field widths fixed by the result format
   localparam int POS_W   = 16;
   localparam int CNT_W   = 4;
   localparam int DEPTH_W = 16;

   // Parameter defaults
   localparam int BUF_BYTES_DEF   = 65536;
   localparam int MAX_OBJECTS_DEF = 8;

   // Reset value of the max_objects register
   localparam logic [CNT_W-1:0] MAX_OBJ_RESET = 4'd8;

   // Characters the scanner reacts to
   localparam logic [7:0] CH_OPEN   = 8'h7B;
   localparam logic [7:0] CH_CLOSE  = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // Result kinds
   localparam logic KIND_OBJECT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Nesting saturation bounds
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

   // All results caused by one input byte: an optional object, an optional summary.
   // The count is the same for both (found after this byte's object, if any).
   typedef struct packed {
      logic             has_obj;
      logic             has_sum;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [CNT_W-1:0] count;
   } jtos_pair_type;

endpackage

/* rtl/jtos_scan.sv */
// jtos_scan: per-byte scanner state (position, nesting, string/escape flags, open object).
// Depends on jtos_pkg.

module jtos_scan #(
   parameter int BUF_BYTES   = jtos_pkg::BUF_BYTES_DEF,
   parameter int MAX_OBJECTS = jtos_pkg::MAX_OBJECTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   text_byte,
   input  logic                         final_byte,
   input  logic [jtos_pkg::CNT_W-1:0]   max_objects,
   output logic                         push,
   output jtos_pkg::jtos_pair_type      pair
);

   localparam logic [jtos_pkg::POS_W-1:0] POS_LAST = jtos_pkg::POS_W'(BUF_BYTES - 1);
   localparam int LIM_CAP = (MAX_OBJECTS > 15) ? 15 : MAX_OBJECTS;
   localparam logic [jtos_pkg::CNT_W-1:0] LIMIT_CAP = jtos_pkg::CNT_W'(LIM_CAP);

   logic [jtos_pkg::POS_W-1:0]          position_ff,   position_in;
   logic signed [jtos_pkg::DEPTH_W-1:0] nesting_ff,    nesting_in;
   logic                                in_string_ff,  in_string_in;
   logic                                escape_ff,     escape_in;
   logic [jtos_pkg::POS_W-1:0]          open_pos_ff,   open_pos_in;
   logic                                open_valid_ff, open_valid_in;
   logic [jtos_pkg::CNT_W-1:0]          found_ff,      found_in;
   logic                                halted_ff,     halted_in;

   logic [jtos_pkg::CNT_W-1:0]          limit;
   logic                                obj_hit;

   assign limit = (max_objects < LIMIT_CAP) ? max_objects : LIMIT_CAP;

   always_comb begin
      position_in   = position_ff;
      nesting_in    = nesting_ff;
      in_string_in  = in_string_ff;
      escape_in     = escape_ff;
      open_pos_in   = open_pos_ff;
      open_valid_in = open_valid_ff;
      found_in      = found_ff;
      halted_in     = halted_ff;
      obj_hit       = 1'b0;

      if (!halted_ff) begin
         if (in_string_ff) begin
            if (escape_ff) begin
               escape_in = 1'b0;
            end else if (text_byte == jtos_pkg::CH_BSLASH) begin
               escape_in = 1'b1;
            end else if (text_byte == jtos_pkg::CH_QUOTE) begin
               in_string_in = 1'b0;
            end
         end else if (text_byte == jtos_pkg::CH_QUOTE) begin
            in_string_in = 1'b1;
         end else if (text_byte == jtos_pkg::CH_OPEN) begin
            if (nesting_ff == '0) begin
               open_pos_in   = position_ff;
               open_valid_in = 1'b1;
            end
            if (nesting_ff != jtos_pkg::DEPTH_MAX) begin
               nesting_in = nesting_ff + 16'sd1;
            end
         end else if (text_byte == jtos_pkg::CH_CLOSE) begin
            if (nesting_ff != jtos_pkg::DEPTH_MIN) begin
               nesting_in = nesting_ff - 16'sd1;
            end
            if (nesting_in == '0 && open_valid_ff) begin
               if (found_ff < limit) begin
                  found_in      = found_ff + 4'd1;
                  obj_hit       = 1'b1;
                  open_valid_in = 1'b0;
               end else begin
                  halted_in = 1'b1;
               end
            end
         end
         if (position_ff != POS_LAST) begin
            position_in = position_ff + 16'd1;
         end
      end

      pair.has_obj   = obj_hit;
      pair.has_sum   = final_byte;
      pair.start_pos = open_pos_ff;
      pair.end_pos   = position_ff;
      pair.count     = found_in;
      push           = accept && (obj_hit || final_byte);

      // end of text: clear the scan for the next buffer
      if (final_byte) begin
         position_in   = '0;
         nesting_in    = '0;
         in_string_in  = 1'b0;
         escape_in     = 1'b0;
         open_pos_in   = '0;
         open_valid_in = 1'b0;
         found_in      = '0;
         halted_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         nesting_ff    <= '0;
         in_string_ff  <= 1'b0;
         escape_ff     <= 1'b0;
         open_pos_ff   <= '0;
         open_valid_ff <= 1'b0;
         found_ff      <= '0;
         halted_ff     <= 1'b0;
      end else if (accept) begin
         position_ff   <= position_in;
         nesting_ff    <= nesting_in;
         in_string_ff  <= in_string_in;
         escape_ff     <= escape_in;
         open_pos_ff   <= open_pos_in;
         open_valid_ff <= open_valid_in;
         found_ff      <= found_in;
         halted_ff     <= halted_in;
      end
   end

   ap_found_limit : assert property (@(posedge clock) disable iff (reset)
      (accept && pair.has_obj) |-> (pair.count <= limit && pair.count != '0))
      else $error("object count beyond limit");

   ap_escape_in_string : assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> in_string_ff)
      else $error("escape pending outside a string");

   ap_halt_no_move : assert property (@(posedge clock) disable iff (reset)
      (halted_ff && accept && !final_byte) |=> $stable(position_ff))
      else $error("position moved while halted");

endmodule

/* rtl/jtos_outq.sv */
// jtos_outq: two-entry result queue; each entry holds one byte's results and is sent
// as one or two beats. Depends on jtos_pkg.

module jtos_outq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  jtos_pkg::jtos_pair_type      pair,
   output logic                         full,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [jtos_pkg::POS_W-1:0]   rsp_start_pos,
   output logic [jtos_pkg::POS_W-1:0]   rsp_end_pos,
   output logic [jtos_pkg::CNT_W-1:0]   rsp_object_count,
   output logic                         rsp_last_of_run
);

   jtos_pkg::jtos_pair_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       phase_ff,  phase_in;

   jtos_pkg::jtos_pair_type head;
   logic show_obj;
   logic beat;
   logic pop;

   assign head      = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign show_obj  = head.has_obj && !phase_ff;

   assign rsp_kind         = show_obj ? jtos_pkg::KIND_OBJECT : jtos_pkg::KIND_SUMMARY;
   assign rsp_start_pos    = show_obj ? head.start_pos : '0;
   assign rsp_end_pos      = show_obj ? head.end_pos : '0;
   assign rsp_object_count = head.count;
   assign rsp_last_of_run  = !show_obj || !head.has_sum;

   assign beat = rsp_valid && !rsp_stall;
   assign pop  = beat && rsp_last_of_run;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      phase_in  = beat ? !rsp_last_of_run : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   ap_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");

   ap_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   ap_phase_pair : assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (rsp_valid && head.has_obj && head.has_sum))
      else $error("second beat pending without a two-result entry");

   ap_ptr_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

/* rtl/json_top_object_splitter.sv */
// json_top_object_splitter: top level of the JSON top-level object splitter.
// Depends on jtos_pkg, jtos_scan and jtos_outq.
//
// Scans a JSON text one byte per req beat and reports each top-level {...} object as a
// rsp beat (kind 0) carrying the byte positions of its opening and closing braces and
// the running object count. Quoted strings and backslash escapes inside them are
// skipped. The byte with req_final_byte set produces a summary beat (kind 1) with the
// object count and then resets the scan for the next text; if it also closes an
// object, the object beat comes first and only the summary has rsp_last_of_run set.
// Once csr max_objects (capped at MAX_OBJECTS) objects have been reported, the next
// completed object halts the scan until the final byte. Positions saturate at
// BUF_BYTES-1 and the nesting depth saturates at the 16-bit signed limits. Rate: one
// byte per clock while req_stall is low; each byte is decoded combinationally against
// the scanner registers and its results go to a two-entry result queue. A byte that
// closes an object on the final byte needs two rsp beats, so a stream of such bytes
// can fill the queue; req_stall rises only when that queue is full. Write csr_wr_data
// only while the block is idle.

module json_top_object_splitter #(
   parameter int BUF_BYTES   = jtos_pkg::BUF_BYTES_DEF,
   parameter int MAX_OBJECTS = jtos_pkg::MAX_OBJECTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   // configuration: max_objects
   input  logic                         csr_wr_en,
   input  logic [jtos_pkg::CNT_W-1:0]   csr_wr_data,

   // input byte channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_text_byte,
   input  logic                         req_final_byte,

   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [jtos_pkg::POS_W-1:0]   rsp_start_pos,
   output logic [jtos_pkg::POS_W-1:0]   rsp_end_pos,
   output logic [jtos_pkg::CNT_W-1:0]   rsp_object_count,
   output logic                         rsp_last_of_run
);

   logic [jtos_pkg::CNT_W-1:0] max_objects_ff;
   logic                       req_accept;
   logic                       push;
   logic                       q_full;
   jtos_pkg::jtos_pair_type    pair;

   // hold the object limit; it is to be written only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         max_objects_ff <= jtos_pkg::MAX_OBJ_RESET;
      end else if (csr_wr_en) begin
         max_objects_ff <= csr_wr_data;
      end
   end

   // stall the byte stream only while the result queue has no free entry
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   // decode the byte and advance the scan state
   jtos_scan #(
      .BUF_BYTES   (BUF_BYTES),
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .text_byte   (req_text_byte),
      .final_byte  (req_final_byte),
      .max_objects (max_objects_ff),
      .push        (push),
      .pair        (pair)
   );

   // queue the byte's results and send them out one beat at a time
   jtos_outq u_outq (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .pair             (pair),
      .full             (q_full),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_pos    (rsp_start_pos),
      .rsp_end_pos      (rsp_end_pos),
      .rsp_object_count (rsp_object_count),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   ap_summary_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == jtos_pkg::KIND_SUMMARY) |-> rsp_last_of_run)
      else $error("summary beat without last_of_run");

   ap_push_needs_accept : assert property (@(posedge clock) disable iff (reset)
      push |-> req_accept)
      else $error("result queued without an accepted byte");

   ap_final_pushes : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_final_byte) |-> push)
      else $error("final byte produced no summary");

endmodule

/* dv/jtos_object_checker.sv */
`timescale 1ns / 1ps
// jtos_object_checker: watches the byte, result and csr ports of json_top_object_splitter,
// predicts every result beat from the accepted byte beats and compares. Needs jtos_pkg.

module jtos_object_checker #(
   parameter int BUF_BYTES   = jtos_pkg::BUF_BYTES_DEF,
   parameter int MAX_OBJECTS = jtos_pkg::MAX_OBJECTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [jtos_pkg::CNT_W-1:0] csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [7:0]                 req_text_byte,
   input  logic                       req_final_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_kind,
   input  logic [jtos_pkg::POS_W-1:0] rsp_start_pos,
   input  logic [jtos_pkg::POS_W-1:0] rsp_end_pos,
   input  logic [jtos_pkg::CNT_W-1:0] rsp_object_count,
   input  logic                       rsp_last_of_run,
   output int                         fail_count,
   output int                         results_owed,
   output int                         bytes_scanned,
   output int                         objects_seen,
   output int                         summaries_seen,
   output int                         halts_seen
);
   import jtos_pkg::*;

   localparam int PRINT_CAP = 50;

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [CNT_W-1:0] count;
      logic             last;
   } split_beat_type;

   split_beat_type owed_beats[$];

   // scanner copy
   logic [CNT_W-1:0]          max_objects_reg;
   logic [POS_W-1:0]          byte_pos;
   logic [POS_W-1:0]          open_pos;
   logic signed [DEPTH_W-1:0] depth;
   logic                      in_string;
   logic                      escaped;
   logic                      open_seen;
   logic                      halted;
   logic [CNT_W-1:0]          found;

   task report_error(input string msg);
      if (fail_count < PRINT_CAP)
         $display("[%0t] jtos checker: %s", $time, msg);
      fail_count++;
   endtask

   task clear_scan();
      byte_pos  = '0;
      open_pos  = '0;
      depth     = '0;
      in_string = 1'b0;
      escaped   = 1'b0;
      open_seen = 1'b0;
      halted    = 1'b0;
      found     = '0;
   endtask

   // Advance the scanner by one byte and queue the beats it causes.
   task scan_byte(input logic [7:0] ch, input logic fin);
      int               limit;
      logic [POS_W-1:0] here;
      split_beat_type   beat;
      limit = (max_objects_reg < MAX_OBJECTS) ? int'(max_objects_reg) : MAX_OBJECTS;
      here  = byte_pos;
      bytes_scanned++;
      if (!halted) begin
         if (in_string) begin
            if (escaped)
               escaped = 1'b0;
            else if (ch == CH_BSLASH)
               escaped = 1'b1;
            else if (ch == CH_QUOTE)
               in_string = 1'b0;
         end else if (ch == CH_QUOTE) begin
            in_string = 1'b1;
         end else if (ch == CH_OPEN) begin
            if (depth == 0) begin
               open_pos  = here;
               open_seen = 1'b1;
            end
            if (depth != DEPTH_MAX)
               depth++;
         end else if (ch == CH_CLOSE) begin
            if (depth != DEPTH_MIN)
               depth--;
            if (depth == 0 && open_seen) begin
               if (found < limit) begin
                  found++;
                  beat.kind      = KIND_OBJECT;
                  beat.start_pos = open_pos;
                  beat.end_pos   = here;
                  beat.count     = found;
                  beat.last      = ~fin;
                  owed_beats.push_back(beat);
                  open_seen = 1'b0;
               end else begin
                  halted = 1'b1;
                  halts_seen++;
               end
            end
         end
         if (byte_pos < BUF_BYTES - 1)
            byte_pos++;
      end
      if (fin) begin
         beat.kind      = KIND_SUMMARY;
         beat.start_pos = '0;
         beat.end_pos   = '0;
         beat.count     = found;
         beat.last      = 1'b1;
         owed_beats.push_back(beat);
         clear_scan();
      end
   endtask

   task check_beat();
      split_beat_type want;
      int             idx;
      idx = objects_seen + summaries_seen;
      if (owed_beats.size() == 0) begin
         report_error($sformatf("rsp beat %0d with nothing owed: kind %0d start %0d end %0d",
                                idx, rsp_kind, rsp_start_pos, rsp_end_pos));
      end else begin
         want = owed_beats.pop_front();
         if (rsp_kind !== want.kind)
            report_error($sformatf("rsp beat %0d kind %0d, want %0d", idx, rsp_kind, want.kind));
         if (rsp_start_pos !== want.start_pos)
            report_error($sformatf("rsp beat %0d start_pos %0d, want %0d",
                                   idx, rsp_start_pos, want.start_pos));
         if (rsp_end_pos !== want.end_pos)
            report_error($sformatf("rsp beat %0d end_pos %0d, want %0d",
                                   idx, rsp_end_pos, want.end_pos));
         if (rsp_object_count !== want.count)
            report_error($sformatf("rsp beat %0d object_count %0d, want %0d",
                                   idx, rsp_object_count, want.count));
         if (rsp_last_of_run !== want.last)
            report_error($sformatf("rsp beat %0d last_of_run %0d, want %0d",
                                   idx, rsp_last_of_run, want.last));
         if (want.kind == KIND_OBJECT)
            objects_seen++;
         else
            summaries_seen++;
      end
   endtask

   // csr first, then the byte beat, then the result beat of the same edge
   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         max_objects_reg = MAX_OBJ_RESET;
         owed_beats.delete();
      end else begin
         if (csr_wr_en)
            max_objects_reg = csr_wr_data;
         if (req_valid && !req_stall)
            scan_byte(req_text_byte, req_final_byte);
         if (rsp_valid && !rsp_stall)
            check_beat();
      end
      results_owed <= owed_beats.size();
   end

endmodule

/* dv/tb_json_top_object_splitter.sv */
`timescale 1ns / 1ps
// tb_json_top_object_splitter: stimulus and verdict for json_top_object_splitter.
// Depends on jtos_pkg, the RTL top and dv/jtos_object_checker.sv.

module tb_json_top_object_splitter;
   import jtos_pkg::*;

   // Cycles with no beat on any port before the run is declared hung. The slowest
   // correct byte costs the longest send gap plus two result beats behind the longest stalls.
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_BYTES  = 1200;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 7;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CNT_W-1:0]     csr_wr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_text_byte;
   logic                 req_final_byte;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_kind;
   logic [POS_W-1:0]     rsp_start_pos;
   logic [POS_W-1:0]     rsp_end_pos;
   logic [CNT_W-1:0]     rsp_object_count;
   logic                 rsp_last_of_run;

   int fail_count;
   int results_owed;
   int bytes_scanned;
   int objects_seen;
   int summaries_seen;
   int halts_seen;

   logic             req_gaps_on = 1'b0;
   logic             rsp_gaps_on = 1'b0;
   int               stall_left  = 0;
   int               quiet_cycles = 0;
   int               texts_sent  = 0;
   logic [7:0]       text_q[$];
   logic [CNT_W-1:0] limit_plan[PHASES];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   json_top_object_splitter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_pos    (rsp_start_pos),
      .rsp_end_pos      (rsp_end_pos),
      .rsp_object_count (rsp_object_count),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   jtos_object_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_pos    (rsp_start_pos),
      .rsp_end_pos      (rsp_end_pos),
      .rsp_object_count (rsp_object_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .fail_count       (fail_count),
      .results_owed     (results_owed),
      .bytes_scanned    (bytes_scanned),
      .objects_seen     (objects_seen),
      .summaries_seen   (summaries_seen),
      .halts_seen       (halts_seen)
   );

   // Result-side back-pressure: raise stall in random bursts while enabled.
   // A burst already started runs to its end even if stalls get switched off.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: count edges with no beat on any port; any beat or reset restarts it.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results still owed",
                  IDLE_LIMIT, results_owed);
         $display("** json_top_object_splitter: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drive one byte beat and hold it until accepted. Enter and leave on a rising edge;
   // valid is only dropped for a gap, never lowered and raised in the same step.
   task send_beat(input logic [7:0] ch, input logic fin);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= ch;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
   endtask

   // Send the queued text; the last byte carries the final mark.
   task send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_beat(text_q[i], i == text_q.size() - 1);
      texts_sent++;
   endtask

   task push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endtask

   // Quoted string with braces, escapes and escaped quotes mixed into the letters.
   // Leave it open when asked, to break the text.
   task add_string(input bit closed);
      int n;
      n = $urandom_range(0, 6);
      text_q.push_back(CH_QUOTE);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0: text_q.push_back(CH_OPEN);
            1: text_q.push_back(CH_CLOSE);
            2: begin
               text_q.push_back(CH_BSLASH);
               text_q.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
               text_q.push_back(CH_BSLASH);
               text_q.push_back(CH_QUOTE);
            end
            default: text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
         endcase
      end
      if (closed)
         text_q.push_back(CH_QUOTE);
   endtask

   // Zero to two "key":value members.
   task add_members();
      int k;
      k = $urandom_range(0, 2);
      for (int m = 0; m < k; m++) begin
         if (m != 0)
            text_q.push_back(CH_COMMA);
         add_string(1'b1);
         text_q.push_back(CH_COLON);
         if ($urandom_range(0, 1) == 1)
            add_string(1'b1);
         else
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
   endtask

   // Object nested up to four deep; now and then drop the outer closing brace.
   task add_object();
      int levels;
      bit broken;
      levels = $urandom_range(0, 3);
      broken = ($urandom_range(0, 15) == 0);
      for (int l = 0; l <= levels; l++) begin
         text_q.push_back(CH_OPEN);
         add_members();
         if (l < levels) begin
            add_string(1'b1);
            text_q.push_back(CH_COLON);
         end
      end
      for (int l = 0; l <= levels; l++) begin
         if (!(l == levels && broken))
            text_q.push_back(CH_CLOSE);
      end
   endtask

   // Mostly well-formed objects; the rest is raw noise, quoted strings, stray braces, spaces and
   // unterminated strings.
   task build_text();
      int parts;
      int pick;
      text_q.delete();
      parts = $urandom_range(1, 5);
      repeat (parts) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            add_object();
         else if (pick < 72)
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
         else if (pick < 80)
            add_string(1'b1);
         else if (pick < 90)
            text_q.push_back(($urandom_range(0, 1) == 1) ? CH_OPEN : CH_CLOSE);
         else if (pick < 95)
            text_q.push_back(CH_SPACE);
         else
            add_string(1'b0);
      end
   endtask

   // Random texts until the byte budget is spent; pick idling per text when allowed.
   task run_random(input int budget, input bit gaps_allowed);
      int sent;
      sent = 0;
      while (sent < budget) begin
         build_text();
         req_gaps_on = gaps_allowed && ($urandom_range(0, 3) != 0);
         rsp_gaps_on = gaps_allowed && ($urandom_range(0, 3) != 0);
         send_text();
         sent += text_q.size();
      end
   endtask

   // Drop valid, wait until every owed result has arrived, then keep the clock running for
   // SETTLE_CYCLES in case a byte with no result is still in flight.
   task settle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_max_objects(input logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= MAX_OBJ_RESET;
      req_valid      <= 1'b0;
      req_text_byte  <= 8'h00;
      req_final_byte <= 1'b0;
      // zero limit, one, a middle value, the 4-bit top (capped), above the cap, a random
      // pick, and the reset value again for the quiet closing phase
      limit_plan = '{4'd0, 4'd1, 4'd2, 4'd15, 4'd9, 4'd5, 4'd8};
      limit_plan[5] = 4'($urandom_range(3, 7));
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed texts at the reset limit, with idling on both sides.
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      // final byte closes an object: object beat first, then the summary
      text_q.delete();
      push_str("{}");
      send_text();
      // braces and an escaped quote inside a string
      text_q.delete();
      push_str("{\"}\\\"{\"}x");
      send_text();
      // unbalanced close drives depth negative; no start recorded, nothing reported
      text_q.delete();
      push_str("}{}");
      send_text();
      // text cut inside a string with an escape pending
      text_q.delete();
      push_str("\"\\");
      send_text();
      // object opened and never closed
      text_q.delete();
      text_q.push_back(CH_OPEN);
      send_text();
      // byte extremes
      text_q.delete();
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      send_text();
      settle();

      // Limit phases: write the register while idle, probe the limit with three small
      // objects, then random texts. The last phase runs without any idling.
      for (int p = 0; p < PHASES; p++) begin
         set_max_objects(limit_plan[p]);
         req_gaps_on = (p != PHASES - 1);
         rsp_gaps_on = (p != PHASES - 1);
         text_q.delete();
         push_str("{}{}{}x");
         send_text();
         run_random(RANDOM_BYTES / PHASES, p != PHASES - 1);
         settle();
      end

      $display("Covered %0d texts, %0d bytes: %0d object and %0d summary beats checked,",
               texts_sent, bytes_scanned, objects_seen, summaries_seen);
      $display("%0d scans halted at the limit; max_objects swept from 0 to 15.",
               halts_seen);
      if (fail_count == 0 && results_owed == 0) begin
         $display("** json_top_object_splitter: PASSED **");
      end else begin
         $display("** json_top_object_splitter: FAILED **");
      end
      $finish;
   end

endmodule
